// ===== rtl/core/hgpe_pkg.sv =====
// Shared types, constants and helpers for the HTTP GET path extractor.
// No dependencies; each other file of the block but the checker imports this package.
package hgpe_pkg;

  // Parse phases of one frame.
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_METHOD,
    PH_PATH,
    PH_IGNORE
  } phase_t;

  // One result item as it travels from the parser to the output stage.
  typedef struct packed {
    logic [7:0] path_byte;
    logic       byte_valid;
    logic       path_end;
    logic [7:0] path_length;
  } result_t;

  // Fixed header byte positions, counted from the destination MAC.
  localparam logic [7:0] POS_ETYPE_HI = 8'd12;
  localparam logic [7:0] POS_ETYPE_LO = 8'd13;
  localparam logic [7:0] POS_IP_VIHL  = 8'd14;
  localparam logic [7:0] POS_IP_PROTO = 8'd23;
  localparam logic [7:0] POS_TCP_DOFF = 8'd46;
  localparam logic [7:0] ETH_HDR_LEN  = 8'd14;
  localparam logic [7:0] POS_MAX      = 8'hFF;

  localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
  localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
  localparam logic [7:0] PROTO_TCP     = 8'h06;
  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] METHOD_LAST_IDX = 8'd3;

  localparam int unsigned PATH_LIMIT_DEF  = 255;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Expected character of the "GET " method word at a given index.
  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = CHAR_G;
      2'd1:    ch = CHAR_E;
      2'd2:    ch = CHAR_T;
      default: ch = CHAR_SPACE;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/core/hgpe_parse.sv =====
// Front part of the path extractor: accepts frame bytes and parses the headers.
// Depends on hgpe_pkg; feeds result items into hgpe_queue.
module hgpe_parse #(
  parameter int unsigned PATH_LIMIT = hgpe_pkg::PATH_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        frame_byte,
  input  logic              frame_last,
  output logic              push,
  output hgpe_pkg::result_t push_data
);
  import hgpe_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [3:0] ihl_r, ihl_nxt;
  logic [7:0] start_r, start_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] cnt_inc;
  logic [7:0] idx;
  logic [3:0] doff;
  logic       end_now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      ihl_r   <= '0;
      start_r <= '0;
      cnt_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      ihl_r   <= ihl_nxt;
      start_r <= start_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    ihl_nxt   = ihl_r;
    start_nxt = start_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    push_data = '0;
    cnt_inc   = cnt_r + 8'd1;
    idx       = pos_r - start_r;
    doff      = frame_byte[7:4];
    end_now   = frame_last || (cnt_inc >= 8'(PATH_LIMIT));
    if (accept) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (pos_r == POS_ETYPE_HI && frame_byte != ETYPE_IPV4_HI) begin
            phase_nxt = PH_IGNORE;
          end else if (pos_r == POS_ETYPE_LO && frame_byte != ETYPE_IPV4_LO) begin
            phase_nxt = PH_IGNORE;
          end else if (pos_r == POS_IP_VIHL) begin
            ihl_nxt = frame_byte[3:0];
            if (frame_byte[3:0] < MIN_HDR_WORDS) begin
              phase_nxt = PH_IGNORE;
            end
          end else if (pos_r == POS_IP_PROTO && frame_byte != PROTO_TCP) begin
            phase_nxt = PH_IGNORE;
          end else if (pos_r == POS_TCP_DOFF) begin
            if (doff < MIN_HDR_WORDS) begin
              phase_nxt = PH_IGNORE;
            end else begin
              start_nxt = ETH_HDR_LEN + {2'b00, ihl_r, 2'b00} + {2'b00, doff, 2'b00};
              phase_nxt = PH_METHOD;
            end
          end
        end
        PH_METHOD: begin
          if (pos_r >= start_r) begin
            if (idx > METHOD_LAST_IDX || frame_byte != get_char(idx[1:0])) begin
              phase_nxt = PH_IGNORE;
            end else if (idx == METHOD_LAST_IDX) begin
              phase_nxt = PH_PATH;
              if (frame_last) begin
                // Frame closes right after the method: empty path.
                push                  = 1'b1;
                push_data.path_end    = 1'b1;
                push_data.path_length = cnt_r;
              end
            end
          end
        end
        PH_PATH: begin
          push = 1'b1;
          if (frame_byte == CHAR_SPACE) begin
            push_data.path_end    = 1'b1;
            push_data.path_length = cnt_r;
            phase_nxt             = PH_IGNORE;
          end else begin
            cnt_nxt               = cnt_inc;
            push_data.path_byte   = frame_byte;
            push_data.byte_valid  = 1'b1;
            push_data.path_end    = end_now;
            push_data.path_length = cnt_inc;
            if (end_now) begin
              phase_nxt = PH_IGNORE;
            end
          end
        end
        PH_IGNORE: begin
          phase_nxt = PH_IGNORE;
        end
      endcase
      // The position counter saturates at 255; every field of interest lies
      // well below that, and the method check rejects anything past it.
      if (frame_last) begin
        phase_nxt = PH_HEADER;
        pos_nxt   = '0;
        ihl_nxt   = '0;
        start_nxt = '0;
        cnt_nxt   = '0;
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + 8'd1;
      end
    end
  end

endmodule

// ===== rtl/core/hgpe_queue.sv =====
// Short result queue between the parser and the output stage.
// Depends on hgpe_pkg for the result item type.
module hgpe_queue #(
  parameter int unsigned DEPTH = hgpe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hgpe_pkg::result_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output hgpe_pkg::result_t head
);
  import hgpe_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  result_t       mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   count_r, count_nxt;

  // DEPTH must be a power of two for the pointers to wrap on their own; the queue does not check it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign full      = (count_r == (AW + 1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

endmodule

// ===== rtl/core/hgpe_out.sv =====
// Back part of the path extractor: output register driving the result channel.
// Depends on hgpe_pkg; drains hgpe_queue.
module hgpe_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  hgpe_pkg::result_t q_head,
  output logic              q_pop,
  input  logic              out_stall,
  output logic              out_valid,
  output hgpe_pkg::result_t out_data
);
  import hgpe_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign q_pop = q_not_empty && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= q_head;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== rtl/core/http_get_path_extractor.sv =====
// Top level of the HTTP GET path extractor.
// Depends on hgpe_pkg, hgpe_parse, hgpe_queue and hgpe_out.
//
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_frame_byte, in_frame_last
// out_      output     out_valid/out_stall  out_path_byte, out_byte_valid,
//                                           out_path_end, out_path_length
//
// The block takes one frame byte every cycle while in_stall is low, with no gaps of its own.
// A result passes through the queue memory and then the output register before it shows on the output.
// Synchronous reset returns the parser to the start of a frame and empties
// the queue; in_stall is low right after reset.
// in_stall rises only while the result queue holds QUEUE_DEPTH results,
// which happens only when the output side stalls.
module http_get_path_extractor #(
  parameter int unsigned PATH_LIMIT  = hgpe_pkg::PATH_LIMIT_DEF,
  parameter int unsigned QUEUE_DEPTH = hgpe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_frame_byte,
  input  logic       in_frame_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_path_byte,
  output logic       out_byte_valid,
  output logic       out_path_end,
  output logic [7:0] out_path_length
);
  import hgpe_pkg::*;

  logic    accept;
  logic    push;
  result_t push_data;
  logic    q_full;
  logic    q_not_empty;
  logic    q_pop;
  result_t q_head;
  result_t out_data;

  // A byte is taken whenever the queue has room; the parser never waits
  // on the output side directly, so bytes keep flowing at one per cycle.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Front: header checks, method match and path streaming.
  hgpe_parse #(
    .PATH_LIMIT(PATH_LIMIT)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .frame_byte(in_frame_byte),
    .frame_last(in_frame_last),
    .push      (push),
    .push_data (push_data)
  );

  // Decoupling queue; a result is pushed only when the queue is not full,
  // since pushes happen only on accepted bytes.
  hgpe_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (q_pop),
    .full     (q_full),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  // Back: output register holding the result until the consumer takes it.
  hgpe_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_not_empty(q_not_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  assign out_path_byte   = out_data.path_byte;
  assign out_byte_valid  = out_data.byte_valid;
  assign out_path_end    = out_data.path_end;
  assign out_path_length = out_data.path_length;

endmodule

// ===== rtl/core/hgpe_checker.sv =====
// Port-level checks of the HTTP GET path extractor, bound to its top level.
// Depends only on the top level's ports.
module hgpe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_path_byte,
  input logic       out_byte_valid,
  input logic       out_path_end,
  input logic [7:0] out_path_length
);

  // Reset empties the output register.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled result stays offered and unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_path_byte) &&
      $stable(out_byte_valid) && $stable(out_path_end) && $stable(out_path_length))
    else $error("stalled result changed");

  // A bare marker always closes the path and carries no character.
  a_bare_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_path_end && (out_path_byte == 8'd0))
    else $error("bare marker without path end");

  // A character result always counts at least that character.
  a_char_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> (out_path_length != 8'd0))
    else $error("character with zero length");

endmodule

bind http_get_path_extractor hgpe_checker u_hgpe_checker (.*);
